/* rtl/tkc_pkg.sv */
// ----------------------------------------------------------------------------
// tkc_pkg
// Types and constants shared by the typed key comparator files.
// ----------------------------------------------------------------------------
package tkc_pkg;

  localparam logic [2:0] OP_INT8   = 3'd0;
  localparam logic [2:0] OP_INT16  = 3'd1;
  localparam logic [2:0] OP_INT32  = 3'd2;
  localparam logic [2:0] OP_FLOAT  = 3'd3;
  localparam logic [2:0] OP_STRING = 3'd4;

  localparam logic [15:0] NULL_LEN = 16'hFFFF;

  // Indicator classes.
  localparam logic [1:0] CLS_EMPTY   = 2'd0;
  localparam logic [1:0] CLS_PRESENT = 2'd1;
  localparam logic [1:0] CLS_NULL    = 2'd2;

  typedef logic signed [16:0] order_t;

  // Class matrix entry that says the values decide.
  localparam logic signed [2:0] PRE_VALUES = 3'sd2;

  function automatic logic [1:0] len_class(input logic [15:0] n);
    if (n == 16'd0) return CLS_EMPTY;
    if (n == NULL_LEN) return CLS_NULL;
    return CLS_PRESENT;
  endfunction

  function automatic logic signed [2:0] class_order(input logic [1:0] ca,
                                                    input logic [1:0] cb);
    logic signed [2:0] r;
    r = 3'sd0;
    case ({ca, cb})
      {CLS_EMPTY, CLS_PRESENT}, {CLS_EMPTY, CLS_NULL},
      {CLS_PRESENT, CLS_NULL}: r = 3'sd1;
      {CLS_PRESENT, CLS_EMPTY}, {CLS_NULL, CLS_EMPTY},
      {CLS_NULL, CLS_PRESENT}: r = -3'sd1;
      {CLS_PRESENT, CLS_PRESENT}: r = PRE_VALUES;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tkc_if.sv */
// ----------------------------------------------------------------------------
// tkc_in_if / tkc_out_if
// Valid/ready channels for key pairs and comparison results.
// ----------------------------------------------------------------------------
interface tkc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic        first_pair;
  logic [15:0] len_a;
  logic [15:0] len_b;
  logic [31:0] value_a;
  logic [31:0] value_b;
  modport source (output valid, opcode, first_pair, len_a, len_b, value_a, value_b,
                  input ready);
  modport sink (input valid, opcode, first_pair, len_a, len_b, value_a, value_b,
                output ready);
endinterface

interface tkc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] order;
  modport source (output valid, order, input ready);
  modport sink (input valid, order, output ready);
endinterface

/* rtl/tkc_compare.sv */
// ----------------------------------------------------------------------------
// tkc_compare
// Compare logic plus string state and result register; one order per item.
// ----------------------------------------------------------------------------
module tkc_compare (
  input  logic                clk,
  input  logic                rst_n,
  tkc_in_if.sink              in_ch,
  input  logic                adv,
  output logic                res_valid,
  output tkc_pkg::order_t     res_order
);
  import tkc_pkg::*;

  logic        str_act_r, str_act_nxt;
  logic [15:0] rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic        emit;
  order_t      ord;
  logic signed [2:0] pre;
  logic signed [8:0] bdiff;
  logic [31:0] ka, kb, ma, mb;
  logic        act;

  assign in_ch.ready = adv;

  // Combinational compare on the incoming transaction.
  always_comb begin
    str_act_nxt = str_act_r;
    rem_a_nxt   = rem_a_r;
    rem_b_nxt   = rem_b_r;
    emit        = 1'b0;
    ord         = '0;
    pre   = class_order(len_class(in_ch.len_a), len_class(in_ch.len_b));
    bdiff = 9'($signed(in_ch.value_a[7:0])) - 9'($signed(in_ch.value_b[7:0]));
    ma = {1'b0, in_ch.value_a[30:0]};
    mb = {1'b0, in_ch.value_b[30:0]};
    ka = in_ch.value_a[31] ? ~in_ch.value_a : (in_ch.value_a | 32'h8000_0000);
    kb = in_ch.value_b[31] ? ~in_ch.value_b : (in_ch.value_b | 32'h8000_0000);
    act = str_act_r;
    if (in_ch.opcode < OP_STRING || (in_ch.opcode == OP_STRING && in_ch.first_pair)) begin
      if (in_ch.opcode == OP_STRING) act = 1'b0;
      if (pre != PRE_VALUES) begin
        emit = 1'b1;
        ord  = 17'(pre);
        if (in_ch.opcode == OP_STRING) str_act_nxt = 1'b0;
      end else begin
        case (in_ch.opcode)
          OP_INT8: begin
            emit = 1'b1;
            ord  = 17'(bdiff);
          end
          OP_INT16: begin
            emit = 1'b1;
            ord  = 17'($signed(in_ch.value_a[15:0])) - 17'($signed(in_ch.value_b[15:0]));
          end
          OP_INT32: begin
            emit = 1'b1;
            if ($signed(in_ch.value_a) > $signed(in_ch.value_b)) ord = 17'sd1;
            else if ($signed(in_ch.value_a) < $signed(in_ch.value_b)) ord = -17'sd1;
          end
          OP_FLOAT: begin
            emit = 1'b1;
            if (ma > 32'h7F80_0000 || mb > 32'h7F80_0000) ord = '0;
            else if (ma == 32'd0 && mb == 32'd0) ord = '0;
            else if (ka > kb) ord = 17'sd1;
            else if (ka < kb) ord = -17'sd1;
          end
          default: begin
            act = 1'b1;
            rem_a_nxt = in_ch.len_a;
            rem_b_nxt = in_ch.len_b;
          end
        endcase
      end
    end
    // String byte step, on the new counts for a first pair.
    if (in_ch.opcode == OP_STRING && act && !emit) begin
      if (bdiff != 9'sd0) begin
        emit = 1'b1;
        ord  = 17'(bdiff);
        str_act_nxt = 1'b0;
      end else if (rem_a_nxt == 16'd1) begin
        emit = 1'b1;
        ord  = 17'sd1 - $signed({1'b0, rem_b_nxt});
        str_act_nxt = 1'b0;
      end else if (rem_b_nxt == 16'd1) begin
        emit = 1'b1;
        ord  = 17'sd1;
        str_act_nxt = 1'b0;
      end else begin
        str_act_nxt = 1'b1;
        rem_a_nxt = rem_a_nxt - 16'd1;
        rem_b_nxt = rem_b_nxt - 16'd1;
      end
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_act_r <= 1'b0;
      rem_a_r   <= '0;
      rem_b_r   <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= in_ch.valid && emit;
      if (in_ch.valid) begin
        str_act_r <= str_act_nxt;
        rem_a_r   <= rem_a_nxt;
        rem_b_r   <= rem_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_order <= ord;
  end

endmodule

/* rtl/typed_key_comparator_core.sv */
// ----------------------------------------------------------------------------
// typed_key_comparator_core
// Compares two database keys of one type and reports their signed order.
// ----------------------------------------------------------------------------
// Usage: key pairs arrive on in_ch (valid/ready); each fixed-width pair gives
// one result on out_ch, and a string is streamed one byte pair per
// transaction with one result when the order is decided.
// Each result is registered and is presented in the cycle after the transaction that gives it is accepted.
// Throughput: one transaction per cycle while the receiver takes each result, set by the single result register.
// The input accepts whenever the result register is empty or being taken,
// so a stalled receiver holds the result and stops the input.
// Reset clears the string state and the result valid flag.
// ----------------------------------------------------------------------------
module typed_key_comparator_core (
  input logic       clk,
  input logic       rst_n,
  tkc_in_if.sink    in_ch,
  tkc_out_if.source out_ch
);
  import tkc_pkg::*;

  logic   res_valid;
  order_t res_order;
  logic   adv;

  // Advance when the result register is free.
  assign adv = !res_valid || out_ch.ready;

  tkc_compare u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .adv       (adv),
    .res_valid (res_valid),
    .res_order (res_order)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.order = res_order;

endmodule
